// File: hw/rtl/resampling_voice_mixer_top_macros.svh
// assertion macros for the resampling voice mixer
`ifndef RESAMPLING_VOICE_MIXER_TOP_MACROS_SVH
`define RESAMPLING_VOICE_MIXER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rvm assertion failed");
// next-cycle implication
`define RVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rvm assertion failed");
`else
`define RVM_ASSERT_NOW(label, ante, cons)
`define RVM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/rvm_pkg.sv
// shared types and constants for the resampling voice mixer
`timescale 1ns / 1ps
package rvm_pkg;

  localparam int VOICE_W     = 3;
  localparam int VOICES_DEF  = 8;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_SHIFT  = 12;
  localparam int POS_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = 32;
  // |sample| * gain fits 33 bits, minus the q4.12 shift
  localparam int PROD_W      = SAMPLE_W + 1 + GAIN_W - GAIN_SHIFT;
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = 72;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [VOICE_W-1:0]         voice;
    logic                       in_range;
    logic                       neg;
    logic [PROD_W-1:0]          prod;
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;
    logic [STEP_W-1:0]          step;
    logic [POS_W-1:0]           sample_count;
    logic                       loop;
    logic                       restart;
  } entry_t;

endpackage

// File: hw/rtl/resampling_voice_mixer_top.sv
// path: an accepted beat is written into the queue, then into the output register, from which it leaves
// throughput: one beat per cycle while the receiver keeps tready high
// the two-entry queue and the output register let either side stall on its own
// reset clears all voice positions to zero, empties the queue and drops tvalid
// top level of the resampling voice mixer
`timescale 1ns / 1ps
`include "resampling_voice_mixer_top_macros.svh"
module resampling_voice_mixer_top import rvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // voice, sample, mix_left, mix_right, gain, step, sample_count, loop, restart
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // left, right, next_position, ended
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  entry_t front_entry, head_entry;
  logic   push, q_full, head_valid, pop;

  rvm_front #(
    .VOICES(VOICES)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (front_entry)
  );

  rvm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head_entry)
  );

  rvm_back #(
    .VOICES(VOICES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (head_valid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // an accepted beat sits in the queue on the next cycle
  `RVM_ASSERT_NEXT(a_accept_queued, s_axis_tvalid_i && s_axis_tready_o, head_valid)
  // a popped entry always lands in the output register
  `RVM_ASSERT_NEXT(a_pop_fills_out, pop, m_axis_tvalid_o)
  // the back end never pops an empty queue
  `RVM_ASSERT_NOW(a_pop_needs_head, pop, head_valid)

endmodule

// File: hw/rtl/rvm_front.sv
// front end: accepts input beats, checks the voice and scales the sample
`timescale 1ns / 1ps
module rvm_front import rvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // voice, sample, mix_left, mix_right, gain, step, sample_count, loop, restart
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output entry_t               entry_o
);

  logic signed [SAMPLE_W-1:0] sample;
  logic [GAIN_W-1:0]          gain;
  logic [SAMPLE_W:0]          s_ext;
  logic [SAMPLE_W:0]          mag;
  logic [SAMPLE_W+GAIN_W:0]   prod_full;

  assign sample = s_axis_tdata_i[18:3];
  assign gain   = s_axis_tdata_i[66:51];

  // magnitude of the sample, 17 bits so -32768 fits
  assign s_ext     = {sample[SAMPLE_W-1], sample};
  assign mag       = sample[SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
  assign prod_full = mag * gain;

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    entry_o.voice        = s_axis_tdata_i[2:0];
    entry_o.in_range     = 32'(s_axis_tdata_i[2:0]) < VOICES;
    entry_o.neg          = sample[SAMPLE_W-1];
    entry_o.prod         = prod_full[SAMPLE_W+GAIN_W:GAIN_SHIFT];
    entry_o.mix_left     = s_axis_tdata_i[34:19];
    entry_o.mix_right    = s_axis_tdata_i[50:35];
    entry_o.step         = s_axis_tdata_i[98:67];
    entry_o.sample_count = s_axis_tdata_i[130:99];
    entry_o.loop         = s_axis_tdata_i[131];
    entry_o.restart      = s_axis_tdata_i[132];
  end

endmodule

// File: hw/rtl/rvm_queue.sv
// short fifo between the front and back ends
`timescale 1ns / 1ps
module rvm_queue import rvm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: hw/rtl/rvm_back.sv
// back end: voice positions, mix, advance, loop wrap and output register
`timescale 1ns / 1ps
module rvm_back import rvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  entry_t               entry_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // left, right, next_position, ended
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // only voices the 3-bit field can name need storage
  localparam int Span  = 2 ** VOICE_W;
  localparam int Depth = (VOICES < Span) ? VOICES : Span;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SumW  = PROD_W + 2;

  logic [POS_W-1:0]  whole_q [Depth];
  logic [FRAC_W-1:0] frac_q  [Depth];

  logic [IdxW-1:0]            idx;
  logic [POS_W-1:0]           pw, whole_adv, whole_new;
  logic [FRAC_W-1:0]          pf, frac_new;
  logic [FRAC_W:0]            nf;
  logic                       stopped, wrap;
  logic signed [PROD_W:0]     sc;
  logic signed [SumW-1:0]     sum_l, sum_r;
  logic signed [SAMPLE_W-1:0] sat_l, sat_r;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] left_q, left_d, right_q, right_d;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic                       ended_q, ended_d;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SumW-1:0] v);
    if (v > SumW'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < SumW'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  assign pop_o = valid_i && (!out_valid_q || m_axis_tready_i);
  assign idx   = entry_i.voice[IdxW-1:0];

  always_comb begin
    pw = entry_i.restart ? '0 : whole_q[idx];
    pf = entry_i.restart ? '0 : frac_q[idx];
    stopped = (pw >= entry_i.sample_count) && !entry_i.loop;

    nf        = {1'b0, pf} + {1'b0, entry_i.step[FRAC_W-1:0]};
    whole_adv = pw + POS_W'(entry_i.step[STEP_W-1:FRAC_W]) + POS_W'(nf[FRAC_W]);
    wrap      = entry_i.loop && (whole_adv >= entry_i.sample_count);

    if (stopped) begin
      whole_new = pw;
      frac_new  = pf;
    end else if (wrap) begin
      whole_new = '0;
      frac_new  = '0;
    end else begin
      whole_new = whole_adv;
      frac_new  = nf[FRAC_W-1:0];
    end

    // scaled sample is symmetric around zero
    sc    = entry_i.neg ? -$signed({1'b0, entry_i.prod}) : $signed({1'b0, entry_i.prod});
    sum_l = SumW'(entry_i.mix_left) + SumW'(sc);
    sum_r = SumW'(entry_i.mix_right) + SumW'(sc);
    sat_l = sat16(sum_l);
    sat_r = sat16(sum_r);

    if (!entry_i.in_range) begin
      left_d  = entry_i.mix_left;
      right_d = entry_i.mix_right;
      pos_d   = '0;
      ended_d = 1'b1;
    end else if (stopped) begin
      left_d  = entry_i.mix_left;
      right_d = entry_i.mix_right;
      pos_d   = pw;
      ended_d = 1'b1;
    end else begin
      left_d  = sat_l;
      right_d = sat_r;
      pos_d   = whole_new;
      ended_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        whole_q[i] <= '0;
        frac_q[i]  <= '0;
      end
    end else if (pop_o && entry_i.in_range) begin
      whole_q[idx] <= whole_new;
      frac_q[idx]  <= frac_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= left_d;
      right_q <= right_d;
      pos_q   <= pos_d;
      ended_q <= ended_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, ended_q, pos_q, right_q, left_q};

endmodule

// File: dv/rvm_mix_checker.sv
// scoreboard for the resampling voice mixer: predicts each result beat and compares it
`timescale 1ns / 1ps
module rvm_mix_checker import rvm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,
  output int                   errors_o,
  output int                   outstanding_o
);

  // input beat, lowest field last
  typedef struct packed {
    logic [2:0]                 pad;
    logic                       restart;
    logic                       loop;
    logic [POS_W-1:0]           sample_count;
    logic [STEP_W-1:0]          step;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] mix_right;
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] sample;
    logic [VOICE_W-1:0]         voice;
  } mix_req_t;

  // result beat, lowest field last
  typedef struct packed {
    logic [6:0]                 pad;
    logic                       ended;
    logic [POS_W-1:0]           next_position;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } mix_result_t;

  logic [POS_W-1:0]  voice_whole [VOICES_DEF];
  logic [FRAC_W-1:0] voice_frac  [VOICES_DEF];
  mix_result_t       mix_pending_q [$];
  int                err_cnt = 0;

  assign errors_o = err_cnt;

  function automatic int clamp16(int v);
    if (v > int'(SAT_MAX)) return int'(SAT_MAX);
    if (v < int'(SAT_MIN)) return int'(SAT_MIN);
    return v;
  endfunction

  // mixes one beat and moves the voice's playback position
  function automatic mix_result_t mix_voice(mix_req_t rq);
    mix_result_t        res;
    logic [VOICE_W-1:0] v;
    int                 mag;
    int                 scaled;
    logic [FRAC_W:0]    frac_sum;
    res = '0;
    v = rq.voice;
    if (rq.restart) begin
      voice_whole[v] = '0;
      voice_frac[v]  = '0;
    end
    // stopped voice passes the mix through untouched
    if (voice_whole[v] >= rq.sample_count && !rq.loop) begin
      res.left          = rq.mix_left;
      res.right         = rq.mix_right;
      res.next_position = voice_whole[v];
      res.ended         = 1'b1;
      return res;
    end
    // magnitude times gain, so the shift truncates toward zero
    mag    = (rq.sample < 0) ? -int'(rq.sample) : int'(rq.sample);
    scaled = int'((longint'(mag) * rq.gain) >> GAIN_SHIFT);
    if (rq.sample < 0) scaled = -scaled;
    res.left  = 16'(clamp16(int'(rq.mix_left) + scaled));
    res.right = 16'(clamp16(int'(rq.mix_right) + scaled));
    frac_sum = {1'b0, voice_frac[v]} + rq.step[FRAC_W-1:0];
    voice_whole[v] = voice_whole[v] + rq.step[STEP_W-1:FRAC_W] + frac_sum[FRAC_W];
    voice_frac[v]  = frac_sum[FRAC_W-1:0];
    if (rq.loop && voice_whole[v] >= rq.sample_count) begin
      voice_whole[v] = '0;
      voice_frac[v]  = '0;
    end
    res.next_position = voice_whole[v];
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t got;
    mix_result_t want;
    if (!rst_ni) begin
      foreach (voice_whole[i]) begin
        voice_whole[i] = '0;
        voice_frac[i]  = '0;
      end
      mix_pending_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (mix_pending_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          err_cnt++;
        end else begin
          want = mix_pending_q.pop_front();
          check_field("left", want.left, got.left);
          check_field("right", want.right, got.right);
          check_field("next_position", want.next_position, got.next_position);
          check_field("ended", want.ended, got.ended);
        end
      end
      if (s_valid_i && s_ready_i) mix_pending_q.push_back(mix_voice(s_data_i));
      outstanding_o <= mix_pending_q.size();
    end
  end

endmodule

// File: dv/tb.sv
// testbench top for the resampling voice mixer: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb;
  import rvm_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 16;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_RARE} rx_mode_e;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data  = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;
  int                   chk_errors;
  int                   outstanding;

  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       idle_count = 0;
  int       burst_left = 0;

  // per-voice sound, held across many beats so positions run to their ends
  logic [POS_W-1:0]  snd_count [VOICES_DEF];
  logic [STEP_W-1:0] snd_step  [VOICES_DEF];
  logic              snd_loop  [VOICES_DEF];

  always #HALF_PERIOD clk = ~clk;

  resampling_voice_mixer_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  rvm_mix_checker i_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_valid_i     (s_valid),
    .s_ready_i     (s_ready),
    .s_data_i      (s_data),
    .m_valid_i     (m_valid),
    .m_ready_i     (m_ready),
    .m_data_i      (m_data),
    .errors_o      (chk_errors),
    .outstanding_o (outstanding)
  );

  // receiver backpressure: open, coin flip or mostly stalled, in stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: m_ready <= 1'b1;
      RX_HALF: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_count <= 0;
      end else if (idle_count == IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  task automatic send_mix(input logic [VOICE_W-1:0] voice, input logic [SAMPLE_W-1:0] sample,
                          input logic [SAMPLE_W-1:0] mix_l, input logic [SAMPLE_W-1:0] mix_r,
                          input logic [GAIN_W-1:0] gain, input logic [STEP_W-1:0] step,
                          input logic [POS_W-1:0] cnt, input logic loop, input logic restart);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= {3'b000, restart, loop, cnt, step, gain, mix_r, mix_l, sample, voice};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic void pick_sound(int v);
    case ($urandom_range(0, 9))
      0, 1:    snd_count[v] = $urandom_range(0, 4);
      2:       snd_count[v] = $urandom;
      default: snd_count[v] = $urandom_range(0, 48);
    endcase
    case ($urandom_range(0, 4))
      0:       snd_step[v] = $urandom_range(0, 3) << FRAC_W;
      1:       snd_step[v] = $urandom_range(0, 16'hFFFF);
      default: snd_step[v] = $urandom_range(0, 32'h0003_0000);
    endcase
    snd_loop[v] = 1'($urandom_range(0, 1));
  endfunction

  initial begin
    int                v;
    logic              rs;
    logic [GAIN_W-1:0] gain;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation at both rails, full gain
    send_mix(3'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 32'h0001_0000, 32'd100, 1'b0, 1'b1);
    send_mix(3'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 32'h0001_0000, 32'd100, 1'b0, 1'b0);
    // negative products truncate toward zero
    send_mix(3'd0, 16'hFFFF, 16'h0000, 16'h0005, 16'h0001, 32'h0000_0000, 32'd100, 1'b0, 1'b0);
    send_mix(3'd0, 16'hF001, 16'h0000, 16'h0000, 16'h0800, 32'h0000_0000, 32'd100, 1'b0, 1'b0);
    // unity and zero gain, fraction carries into whole
    send_mix(3'd1, 16'h1234, 16'h0100, 16'hFF00, 16'h1000, 32'h0000_8000, 32'd100, 1'b0, 1'b1);
    send_mix(3'd1, 16'h1234, 16'h0100, 16'hFF00, 16'h0000, 32'h0000_8000, 32'd100, 1'b0, 1'b0);
    send_mix(3'd1, 16'h4321, 16'h0000, 16'h0000, 16'h2000, 32'h0000_FFFF, 32'd100, 1'b0, 1'b0);
    // zero length sound, stopped and looping
    send_mix(3'd2, 16'h0100, 16'h0010, 16'h0020, 16'h1000, 32'h0001_0000, 32'd0, 1'b0, 1'b1);
    send_mix(3'd2, 16'h0100, 16'h0010, 16'h0020, 16'h1000, 32'h0001_0000, 32'd0, 1'b1, 1'b0);
    // looping voice wraps to zero right after reaching its length
    for (int i = 0; i < 4; i++) begin
      send_mix(3'd3, 16'h0200, 16'h0000, 16'h0000, 16'h1000, 32'h0001_0000, 32'd3, 1'b1,
               1'(i == 0));
    end
    // non-looping voice stops, then loops from past its end, then restarts
    send_mix(3'd4, 16'h0300, 16'h0001, 16'h0002, 16'h1000, 32'h0002_0000, 32'd3, 1'b0, 1'b1);
    send_mix(3'd4, 16'h0300, 16'h0001, 16'h0002, 16'h1000, 32'h0002_0000, 32'd3, 1'b0, 1'b0);
    send_mix(3'd4, 16'h0300, 16'h0001, 16'h0002, 16'h1000, 32'h0002_0000, 32'd3, 1'b0, 1'b0);
    send_mix(3'd4, 16'h0300, 16'h0001, 16'h0002, 16'h1000, 32'h0002_0000, 32'd3, 1'b1, 1'b0);
    send_mix(3'd4, 16'h0300, 16'h0001, 16'h0002, 16'h1000, 32'h0002_0000, 32'd3, 1'b0, 1'b1);
    // largest step and length
    send_mix(3'd5, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
             1'b1);
    send_mix(3'd5, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
             1'b0);
    wait_drained();

    for (int i = 0; i < VOICES_DEF; i++) pick_sound(i);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      v = $urandom_range(0, VOICES_DEF - 1);
      if ($urandom_range(0, 99) < 15) begin
        send_mix(VOICE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                 SAMPLE_W'($urandom), GAIN_W'($urandom), $urandom, $urandom,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        rs = ($urandom_range(0, 31) == 0);
        if ($urandom_range(0, 39) == 0) begin
          pick_sound(v);
          rs = 1'($urandom_range(0, 1));
        end
        gain = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 16'h2000))
                                    : GAIN_W'($urandom);
        send_mix(VOICE_W'(v), SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                 gain, snd_step[v], snd_count[v], snd_loop[v], rs);
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (chk_errors == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rvm_pkg.sv
hw/rtl/rvm_front.sv
hw/rtl/rvm_queue.sv
hw/rtl/rvm_back.sv
hw/rtl/resampling_voice_mixer_top.sv
dv/rvm_mix_checker.sv
dv/tb.sv
